@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CEDE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define CEDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/cede_pkg.sv @@
// Package for the counter extend / drift estimator: widths, constants, unit result types.
// No dependencies.
package cede_pkg;

	localparam int CNT_W    = 32;
	localparam int WALL_W   = 64;
	localparam int PERIOD_W = 48;
	localparam int TIME_W   = 63;
	localparam int RATE_W   = 30;
	localparam int ALPHA_W  = 10;

	// shift-add multiplier: A operand x B operand, B consumed one bit per cycle
	localparam int MUL_A_W = 64;
	localparam int MUL_B_W = 48;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// restoring divider: dividend consumed one bit per cycle
	localparam int DIV_N_W = 94;
	localparam int DIV_D_W = 64;
	localparam int DIV_Q_W = 31;

	// blend sum width: 1000 * 1.05e9 < 2^40
	localparam int SUM_W = 41;

	localparam logic [RATE_W-1:0]  RATE_ONE  = 30'd1000000000;
	localparam logic [RATE_W-1:0]  RATE_MIN  = 30'd950000000;
	localparam logic [RATE_W-1:0]  RATE_MAX  = 30'd1050000000;
	localparam logic [ALPHA_W-1:0] ALPHA_DEN = 10'd1000;

	// register indexes, byte address = 8 * index
	localparam logic [2:0] REG_EVENT_FALLBACK = 3'd0;
	localparam logic [2:0] REG_TICK_PERIOD    = 3'd1;
	localparam logic [2:0] REG_UPDATE_INTERVAL = 3'd2;
	localparam logic [2:0] REG_MIN_WINDOW     = 3'd3;
	localparam logic [2:0] REG_ALPHA          = 3'd4;

	typedef struct packed {
		logic               done;
		logic [MUL_P_W-1:0] prod;
	} mul_res_t;

	typedef struct packed {
		logic               done;
		logic               over;
		logic [DIV_Q_W-1:0] quo;
	} div_res_t;

endpackage

@@ rtl/cede_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on cede_pkg.
module cede_mul (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [cede_pkg::MUL_A_W-1:0] a,
	input  logic [cede_pkg::MUL_B_W-1:0] b,
	output cede_pkg::mul_res_t       res
);
	import cede_pkg::*;

	localparam int CNT_W_L = $clog2(MUL_B_W);
	localparam logic [CNT_W_L-1:0] LAST = CNT_W_L'(MUL_B_W - 1);

	logic [MUL_A_W-1:0] a_q;
	logic [MUL_A_W-1:0] hi_q;
	logic [MUL_B_W-1:0] lo_q;
	logic [CNT_W_L-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [MUL_A_W:0]   sum;

	// add A when the current low bit is set, then shift the product right
	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[MUL_A_W:1];
			lo_q <= {sum[0], lo_q[MUL_B_W-1:1]};
		end
	end

	assign res.done = done_q;
	assign res.prod = {hi_q, lo_q};

endmodule

@@ rtl/cede_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle, with quotient overflow flag.
// Depends on cede_pkg.
module cede_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [cede_pkg::DIV_N_W-1:0] num,
	input  logic [cede_pkg::DIV_D_W-1:0] den,
	output cede_pkg::div_res_t       res
);
	import cede_pkg::*;

	localparam int CNT_W_L = $clog2(DIV_N_W);
	localparam logic [CNT_W_L-1:0] LAST = CNT_W_L'(DIV_N_W - 1);

	logic [DIV_N_W-1:0] num_q;
	logic [DIV_D_W-1:0] den_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_Q_W-1:0] quo_q;
	logic               over_q;
	logic [CNT_W_L-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DIV_D_W:0]   rem_sh;
	logic [DIV_D_W:0]   rem_sub;
	logic               ge;

	assign rem_sh  = {rem_q, num_q[DIV_N_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quo_q  <= '0;
			over_q <= 1'b0;
		end else if (busy_q) begin
			num_q  <= {num_q[DIV_N_W-2:0], 1'b0};
			rem_q  <= ge ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
			// a set bit leaving the top means the quotient exceeds the kept width
			over_q <= over_q | quo_q[DIV_Q_W-1];
			quo_q  <= {quo_q[DIV_Q_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.over = over_q;
	assign res.quo  = quo_q;

endmodule

@@ rtl/counter_extend_drift_estimator_core.sv @@
// Top level of the counter extend / drift estimator: APB registers, sequencer, state.
// Depends on cede_pkg, cede_mul, cede_div.
//
// Each input transaction carries a 32-bit sample counter value and a wall time. The block
// extends the counter to 64 bits by counting wraps (a value below the previous one), scales
// ticks to nanoseconds with tick_period (FRAC_BITS fraction bits, result saturated to
// 2^63-1) and returns one output transaction per input: time_ns, device_error and the
// filtered rate in ppb. At most once per update_interval_ns of wall time it measures
// counter advance over wall advance since the baseline, clamps it to 0.95e9..1.05e9 and
// blends it in with weight alpha/1000 (alpha above 1000 acts as 1000). With event_fallback
// set, reads return the last noted frame-event time and a rate of 1e9; a note command only
// stores its event time in that mode. A failed read returns error with time 0 and changes
// nothing. One transaction is worked on at a time. Notes, fallback reads and failed reads
// go straight to the output register; a counter read runs the 48-step shift-add multiplier
// once; an estimator update adds two blend multiplies, a ppb product pass and two passes of
// the 94-step restoring divider (a counter behind its baseline skips the ppb pass and one
// division). The next input is taken once the result sits in the output register, even if
// the sink has not taken it yet. Configuration must be written only while idle; the block does not enforce it.
module counter_extend_drift_estimator_core #(
	parameter int FRAC_BITS = 24   // 16..32
) (
	input  logic         clk,
	input  logic         arst_n,
	// APB configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,  // counter_low[31:0], wall_ns[95:32], event_time_ns[159:96]
	input  logic [1:0]   s_tuser,  // cmd[0], counter_ok[1]
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,  // time_ns[62:0], rate_ppb[92:63], zero pad[95:93]
	output logic         m_tuser   // device_error
);
	import cede_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_MUL_T = 9'b000000010,  // ticks x tick_period
		ST_CHK   = 9'b000000100,  // baseline / interval checks
		ST_MUL_C = 9'b000001000,  // counter delta x 1e9
		ST_DIV_C = 9'b000010000,  // / wall delta
		ST_MUL_A = 9'b000100000,  // alpha x ppb
		ST_MUL_B = 9'b001000000,  // (1000 - alpha) x rate
		ST_DIV_K = 9'b010000000,  // / 1000
		ST_DONE  = 9'b100000000   // wait for output register
	} state_t;

	state_t state_q;

	// config registers
	logic                 event_fallback_q;
	logic [PERIOD_W-1:0]  tick_period_q;
	logic [31:0]          update_interval_q;
	logic [31:0]          min_window_q;
	logic [ALPHA_W-1:0]   alpha_q;

	// persistent state
	logic                 shadow_valid_q;
	logic [CNT_W-1:0]     prev_low_q;
	logic [CNT_W-1:0]     wrap_q;
	logic                 base_valid_q;
	logic [WALL_W-1:0]    base_wall_q;
	logic [TIME_W-1:0]    base_ns_q;
	logic [WALL_W-1:0]    last_upd_q;
	logic [RATE_W-1:0]    rate_q;
	logic [WALL_W-1:0]    last_event_q;

	// per-transaction working registers
	logic [WALL_W-1:0]    wall_q;
	logic [TIME_W-1:0]    ns_q;
	logic [WALL_W-1:0]    wd_q;
	logic [SUM_W-1:0]     sum_q;
	logic [TIME_W-1:0]    res_time_q;
	logic                 res_err_q;
	logic [RATE_W-1:0]    res_rate_q;

	// output register
	logic                 m_tvalid_q;
	logic [TIME_W-1:0]    out_time_q;
	logic                 out_err_q;
	logic [RATE_W-1:0]    out_rate_q;

	// unit control
	logic                 mul_go_q;
	logic [MUL_A_W-1:0]   mul_a_q;
	logic [MUL_B_W-1:0]   mul_b_q;
	logic                 div_go_q;
	logic [DIV_N_W-1:0]   div_n_q;
	logic [DIV_D_W-1:0]   div_d_q;
	mul_res_t             mul_res;
	div_res_t             div_res;

	// input fields
	logic                 in_cmd;
	logic                 in_ok;
	logic [CNT_W-1:0]     in_low;
	logic [WALL_W-1:0]    in_wall;
	logic [WALL_W-1:0]    in_event;
	logic                 in_acc;
	logic [CNT_W-1:0]     wrap_nxt;

	// combinational helpers
	logic                 cfg_wr;
	logic [TIME_W-1:0]    ns_sat;
	logic [WALL_W-1:0]    upd_d;
	logic [WALL_W-1:0]    win_d;
	logic                 upd_ok;
	logic                 win_ok;
	logic                 ns_ge;
	logic [TIME_W-1:0]    cd;
	logic [ALPHA_W-1:0]   a_cl;
	logic [RATE_W-1:0]    ppb_cl;
	logic [SUM_W-1:0]     blend_sum;

	assign in_cmd   = s_tuser[0];
	assign in_ok    = s_tuser[1];
	assign in_low   = s_tdata[31:0];
	assign in_wall  = s_tdata[95:32];
	assign in_event = s_tdata[159:96];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// wrap detection: first read starts the high word at zero
	always_comb begin
		if (!shadow_valid_q) begin
			wrap_nxt = '0;
		end else if (in_low < prev_low_q) begin
			wrap_nxt = wrap_q + 1'b1;
		end else begin
			wrap_nxt = wrap_q;
		end
	end

	// ns = floor(ticks * period / 2^FRAC_BITS), saturated
	always_comb begin
		if (mul_res.prod[MUL_P_W-1:FRAC_BITS+TIME_W] != '0) begin
			ns_sat = '1;
		end else begin
			ns_sat = mul_res.prod[FRAC_BITS+TIME_W-1:FRAC_BITS];
		end
	end

	// wall differences are exact; a negative one never passes
	assign upd_d  = wall_q - last_upd_q;
	assign win_d  = wall_q - base_wall_q;
	assign upd_ok = ($signed(wall_q) >= $signed(last_upd_q)) &&
		(upd_d >= {32'd0, update_interval_q});
	assign win_ok = ($signed(wall_q) >= $signed(base_wall_q)) && (win_d != '0) &&
		(win_d >= {32'd0, min_window_q});
	assign ns_ge  = ns_q >= base_ns_q;
	assign cd     = ns_q - base_ns_q;

	assign a_cl = (alpha_q > ALPHA_DEN) ? ALPHA_DEN : alpha_q;

	// clamp measured ratio
	always_comb begin
		if (div_res.over || (div_res.quo > {1'b0, RATE_MAX})) begin
			ppb_cl = RATE_MAX;
		end else if (div_res.quo < {1'b0, RATE_MIN}) begin
			ppb_cl = RATE_MIN;
		end else begin
			ppb_cl = div_res.quo[RATE_W-1:0];
		end
	end

	assign blend_sum = sum_q + mul_res.prod[SUM_W-1:0];

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[5:3])
			REG_EVENT_FALLBACK:  prdata = 64'(event_fallback_q);
			REG_TICK_PERIOD:     prdata = 64'(tick_period_q);
			REG_UPDATE_INTERVAL: prdata = 64'(update_interval_q);
			REG_MIN_WINDOW:      prdata = 64'(min_window_q);
			REG_ALPHA:           prdata = 64'(alpha_q);
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_fallback_q  <= 1'b0;
			tick_period_q     <= '0;
			update_interval_q <= 32'd1000000000;
			min_window_q      <= 32'd1000000000;
			alpha_q           <= 10'd100;
		end else if (cfg_wr) begin
			unique case (paddr[5:3])
				REG_EVENT_FALLBACK:  event_fallback_q  <= pwdata[0];
				REG_TICK_PERIOD:     tick_period_q     <= pwdata[PERIOD_W-1:0];
				REG_UPDATE_INTERVAL: update_interval_q <= pwdata[31:0];
				REG_MIN_WINDOW:      min_window_q      <= pwdata[31:0];
				REG_ALPHA:           alpha_q           <= pwdata[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			shadow_valid_q <= 1'b0;
			prev_low_q     <= '0;
			wrap_q         <= '0;
			base_valid_q   <= 1'b0;
			base_wall_q    <= '0;
			base_ns_q      <= '0;
			last_upd_q     <= '0;
			rate_q         <= RATE_ONE;
			last_event_q   <= '0;
			mul_go_q       <= 1'b0;
			div_go_q       <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			// unit start pulses, raised where a state hands over to a unit
			mul_go_q <= ((state_q == ST_IDLE) && in_acc && !in_cmd && !event_fallback_q &&
					in_ok) ||
				((state_q == ST_CHK) && base_valid_q && upd_ok && win_ok) ||
				((state_q == ST_DIV_C) && div_res.done) ||
				((state_q == ST_MUL_A) && mul_res.done);
			div_go_q <= ((state_q == ST_MUL_C) && mul_res.done) ||
				((state_q == ST_MUL_B) && mul_res.done);
			// output register: load a finished result, else drop it once taken
			if ((state_q == ST_DONE) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_cmd) begin
							if (event_fallback_q) begin
								last_event_q <= in_event;
							end
							state_q <= ST_DONE;
						end else if (event_fallback_q || !in_ok) begin
							state_q <= ST_DONE;
						end else begin
							shadow_valid_q <= 1'b1;
							wrap_q         <= wrap_nxt;
							prev_low_q     <= in_low;
							state_q        <= ST_MUL_T;
						end
					end
				end
				ST_MUL_T: begin
					if (mul_res.done) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (!base_valid_q) begin
						base_valid_q <= 1'b1;
						base_wall_q  <= wall_q;
						base_ns_q    <= ns_q;
						last_upd_q   <= wall_q;
						state_q      <= ST_DONE;
					end else if (upd_ok) begin
						last_upd_q <= wall_q;
						if (win_ok) begin
							state_q <= ns_ge ? ST_MUL_C : ST_MUL_A;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_MUL_C: begin
					if (mul_res.done) begin
						state_q <= ST_DIV_C;
					end
				end
				ST_DIV_C: begin
					if (div_res.done) begin
						state_q <= ST_MUL_A;
					end
				end
				ST_MUL_A: begin
					if (mul_res.done) begin
						state_q <= ST_MUL_B;
					end
				end
				ST_MUL_B: begin
					if (mul_res.done) begin
						state_q <= ST_DIV_K;
					end
				end
				ST_DIV_K: begin
					if (div_res.done) begin
						rate_q  <= div_res.quo[RATE_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				wall_q    <= in_wall;
				mul_a_q   <= {wrap_nxt, in_low};
				mul_b_q   <= tick_period_q;
				if (in_cmd) begin
					res_time_q <= '0;
					res_err_q  <= 1'b0;
					res_rate_q <= event_fallback_q ? RATE_ONE : rate_q;
				end else if (event_fallback_q) begin
					res_time_q <= last_event_q[WALL_W-1] ? '0 : last_event_q[TIME_W-1:0];
					res_err_q  <= 1'b0;
					res_rate_q <= RATE_ONE;
				end else begin
					res_time_q <= '0;
					res_err_q  <= 1'b1;
					res_rate_q <= rate_q;
				end
			end
			ST_MUL_T: begin
				ns_q       <= ns_sat;
				res_time_q <= ns_sat;
				res_err_q  <= 1'b0;
				res_rate_q <= rate_q;
			end
			ST_CHK: begin
				wd_q <= win_d;
				if (ns_ge) begin
					mul_a_q <= {1'b0, cd};
					mul_b_q <= MUL_B_W'(RATE_ONE);
				end else begin
					// counter went backwards: measurement is the minimum
					mul_a_q <= MUL_A_W'(RATE_MIN);
					mul_b_q <= MUL_B_W'(a_cl);
				end
			end
			ST_MUL_C: begin
				div_n_q <= mul_res.prod[DIV_N_W-1:0];
				div_d_q <= wd_q;
			end
			ST_DIV_C: begin
				mul_a_q <= MUL_A_W'(ppb_cl);
				mul_b_q <= MUL_B_W'(a_cl);
			end
			ST_MUL_A: begin
				sum_q   <= mul_res.prod[SUM_W-1:0];
				mul_a_q <= MUL_A_W'(rate_q);
				mul_b_q <= MUL_B_W'(ALPHA_DEN - a_cl);
			end
			ST_MUL_B: begin
				div_n_q <= DIV_N_W'(blend_sum);
				div_d_q <= DIV_D_W'(ALPHA_DEN);
			end
			ST_DIV_K: begin
				res_rate_q <= div_res.quo[RATE_W-1:0];
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_time_q <= res_time_q;
					out_err_q  <= res_err_q;
					out_rate_q <= res_rate_q;
				end
			end
			default: ;
		endcase
	end

	cede_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.res    (mul_res)
	);

	cede_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (div_n_q),
		.den    (div_d_q),
		.res    (div_res)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, out_rate_q, out_time_q};
	assign m_tuser  = out_err_q;

endmodule

@@ rtl/cede_checker.sv @@
// Port-level checker for the counter extend / drift estimator, bound to the top level.
// Depends on cede_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cede_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic        m_tuser
);
	import cede_pkg::*;

	`CEDE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output transaction changed while stalled")

	`CEDE_ASSERT_IMPL(a_err_time_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata[62:0] == '0, "device error with nonzero time")

	`CEDE_ASSERT_IMPL(a_rate_range, clk, arst_n, m_tvalid, (m_tdata[92:63] >= RATE_MIN) && (m_tdata[92:63] <= RATE_MAX), "rate outside clamp range")

	`CEDE_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready, "input taken while busy")

endmodule

bind counter_extend_drift_estimator_core cede_checker u_cede_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ verif/tb_counter_extend_drift_estimator_core.sv @@
// Testbench for counter_extend_drift_estimator_core: drives counter reads and frame-event notes,
// predicts each result from its own copy of the clock state and checks it field by field.
// Depends on cede_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_counter_extend_drift_estimator_core;
	import cede_pkg::*;

	localparam int          FRAC_BITS  = 24;
	localparam logic        CMD_READ   = 1'b0;
	localparam logic        CMD_NOTE   = 1'b1;
	localparam logic [63:0] TIME_CEIL  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ONE_NS_TICK = 64'd16777216;  // 1.0 ns with 24 fraction bits

	typedef enum int {SINK_FREE, SINK_HALF, SINK_SLOW} sink_pace_t;

	// one result transaction
	typedef struct packed {
		logic [62:0] time_ns;
		logic        device_error;
		logic [29:0] rate_ppb;
	} clock_result_t;

	logic         clk;
	logic         arst_n;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [5:0]   paddr;
	logic [63:0]  pwdata;
	logic [63:0]  prdata;
	logic         pready;
	logic         s_tvalid;
	logic         s_tready;
	logic [159:0] s_tdata;  // counter_low[31:0], wall_ns[95:32], event_time_ns[159:96]
	logic [1:0]   s_tuser;  // cmd[0], counter_ok[1]
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;  // time_ns[62:0], rate_ppb[92:63], zero pad[95:93]
	logic         m_tuser;  // device_error

	counter_extend_drift_estimator_core #(
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// ---------------------------------------------------------------------------------
	// Predictor: register copies and clock state, at reset values.
	// ---------------------------------------------------------------------------------
	logic        cfg_fallback = 1'b0;
	logic [47:0] cfg_period   = 48'd0;
	logic [31:0] cfg_interval = 32'd1000000000;
	logic [31:0] cfg_window   = 32'd1000000000;
	logic [9:0]  cfg_alpha    = 10'd100;

	logic        wrap_seen     = 1'b0;  // wrap detector primed by first good read
	logic [31:0] last_low      = '0;
	logic [31:0] wrap_count    = '0;
	logic        base_set      = 1'b0;
	logic [63:0] base_wall     = '0;
	logic [63:0] base_cnt_ns   = '0;
	logic [63:0] last_upd_wall = '0;
	logic [29:0] rate_flt      = RATE_ONE;
	logic [63:0] event_ns      = '0;

	clock_result_t clock_expect[$];  // results still owed by the block, oldest first
	int            mismatch_count = 0;
	int            burst_left     = 0;  // transactions left in the current sender burst

	// ticks * period / 2^FRAC_BITS, floor, saturated to the 63-bit range
	function automatic logic [63:0] scale_ticks(input logic [63:0] ticks);
		logic [111:0] prod;
		prod = {48'd0, ticks} * {64'd0, cfg_period};
		prod = prod >> FRAC_BITS;
		if (prod > {48'd0, TIME_CEIL})
			return TIME_CEIL;
		return prod[63:0];
	endfunction

	// signed a >= signed b; the unsigned difference is then exact
	function automatic bit wall_ahead(input logic [63:0] a, input logic [63:0] b);
		return $signed(a) >= $signed(b);
	endfunction

	// expected result of one input transaction; updates the predictor state
	function automatic clock_result_t predict_clock(input logic cmd, input logic [31:0] low,
			input logic ok, input logic [63:0] wall, input logic [63:0] evt);
		clock_result_t r;
		logic [63:0]   cns;
		logic [63:0]   wd;
		logic [127:0]  ratio;
		logic [29:0]   ppb;
		logic [63:0]   a64;
		logic [63:0]   den64;
		logic [63:0]   mix;
		r = '0;
		// notes store the event time only in fallback mode
		if (cmd == CMD_NOTE) begin
			if (cfg_fallback)
				event_ns = evt;
			r.rate_ppb = cfg_fallback ? RATE_ONE : rate_flt;
			return r;
		end
		// fallback read: last event time, negative shown as zero
		if (cfg_fallback) begin
			r.time_ns  = event_ns[63] ? 63'd0 : event_ns[62:0];
			r.rate_ppb = RATE_ONE;
			return r;
		end
		// failed read leaves all state alone
		if (!ok) begin
			r.device_error = 1'b1;
			r.rate_ppb     = rate_flt;
			return r;
		end
		if (!wrap_seen) begin
			wrap_count = '0;
			wrap_seen  = 1'b1;
		end else if (low < last_low) begin
			wrap_count = wrap_count + 32'd1;
		end
		last_low = low;
		cns = scale_ticks({wrap_count, low});
		if (!base_set) begin
			// first good read only sets the baseline
			base_wall     = wall;
			base_cnt_ns   = cns;
			last_upd_wall = wall;
			base_set      = 1'b1;
		end else if (wall_ahead(wall, last_upd_wall) &&
				(wall - last_upd_wall) >= {32'd0, cfg_interval}) begin
			wd = wall - base_wall;
			if (wall_ahead(wall, base_wall) && wd != 0 && wd >= {32'd0, cfg_window}) begin
				a64   = (cfg_alpha > ALPHA_DEN) ? {54'd0, ALPHA_DEN} : {54'd0, cfg_alpha};
				den64 = {54'd0, ALPHA_DEN};
				if (cns >= base_cnt_ns) begin
					ratio = {64'd0, cns - base_cnt_ns} * 128'd1000000000;
					ratio = ratio / {64'd0, wd};
					if (ratio > RATE_MAX)
						ppb = RATE_MAX;
					else if (ratio < RATE_MIN)
						ppb = RATE_MIN;
					else
						ppb = ratio[29:0];
				end else begin
					// counter went behind its baseline
					ppb = RATE_MIN;
				end
				mix = ((den64 - a64) * {34'd0, rate_flt} + a64 * {34'd0, ppb}) / den64;
				rate_flt = mix[29:0];
			end
			last_upd_wall = wall;
		end
		r.time_ns  = cns[62:0];
		r.rate_ppb = rate_flt;
		return r;
	endfunction

	// ---------------------------------------------------------------------------------
	// Clock, sink pacing, result checking, run limit
	// ---------------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// sink stalls on a pattern of its own: free-running, coin flip, or mostly stalled
	initial begin : sink_pacing
		sink_pace_t pace;
		int         pace_left;
		pace      = SINK_FREE;
		pace_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (pace_left == 0) begin
				pace      = sink_pace_t'($urandom_range(0, 2));
				pace_left = $urandom_range(20, 300);
			end
			pace_left--;
			case (pace)
				SINK_FREE: begin
					m_tready <= 1'b1;
				end
				SINK_HALF: begin
					m_tready <= 1'($urandom_range(0, 1));
				end
				default: begin
					m_tready <= ($urandom_range(0, 3) == 0);
				end
			endcase
		end
	end

	// every accepted result transaction is held against the oldest prediction
	always @(posedge clk) begin : result_check
		clock_result_t want;
		clock_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.time_ns      = m_tdata[62:0];
			got.rate_ppb     = m_tdata[92:63];
			got.device_error = m_tuser;
			if (clock_expect.size() == 0) begin
				$error("result transaction with no prediction waiting");
				mismatch_count++;
			end else begin
				want = clock_expect.pop_front();
				if (got.time_ns !== want.time_ns) begin
					$error("time_ns: expected %0d, actual %0d", want.time_ns, got.time_ns);
					mismatch_count++;
				end
				if (got.device_error !== want.device_error) begin
					$error("device_error: expected %0d, actual %0d",
						want.device_error, got.device_error);
					mismatch_count++;
				end
				if (got.rate_ppb !== want.rate_ppb) begin
					$error("rate_ppb: expected %0d, actual %0d", want.rate_ppb, got.rate_ppb);
					mismatch_count++;
				end
			end
		end
	end

	// worst case of ~800 transactions ends far below this limit
	initial begin : run_limit
		#50_000_000;
		$display("Mismatches found");
		$finish;
	end

	// ---------------------------------------------------------------------------------
	// Shared driving tasks
	// ---------------------------------------------------------------------------------

	// hold the input off until every predicted result has arrived
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (clock_expect.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// register write over APB, only with the block idle
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		wait_drained();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_EVENT_FALLBACK:  cfg_fallback = value[0];
			REG_TICK_PERIOD:     cfg_period   = value[47:0];
			REG_UPDATE_INTERVAL: cfg_interval = value[31:0];
			REG_MIN_WINDOW:      cfg_window   = value[31:0];
			REG_ALPHA:           cfg_alpha    = value[9:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// one input transaction; sender works in bursts with random gaps between them
	task automatic send_item(input logic cmd, input logic [31:0] low, input logic ok,
			input logic [63:0] wall, input logic [63:0] evt);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		s_tdata  <= {evt, wall, low};
		s_tuser  <= {ok, cmd};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		clock_expect.push_back(predict_clock(cmd, low, ok, wall, evt));
	endtask

	// ---------------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------------

	// field extremes, both commands, clamps, wall going back, wraps, fallback cases
	task automatic test_directed();
		// reset registers: period 0, so time reads 0
		send_item(CMD_READ, 32'hFFFF_FFFF, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
		send_item(CMD_NOTE, 32'h0, 1'b1, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
		// 1 ns per tick, estimator updates on every read, new measurement taken whole
		write_reg(REG_TICK_PERIOD, ONE_NS_TICK);
		write_reg(REG_UPDATE_INTERVAL, 64'd0);
		write_reg(REG_MIN_WINDOW, 64'd0);
		write_reg(REG_ALPHA, {54'd0, ALPHA_DEN});
		send_item(CMD_READ, 32'd1000, 1'b1, 64'd1000, 64'd0);  // baseline
		send_item(CMD_READ, 32'd1100, 1'b1, 64'd1100, 64'd0);  // exactly nominal
		send_item(CMD_READ, 32'd1300, 1'b1, 64'd1150, 64'd0);  // fast, clamps high
		send_item(CMD_READ, 32'd1400, 1'b1, 64'd2000, 64'd0);  // slow, clamps low
		send_item(CMD_READ, 32'd1500, 1'b1, 64'd1900, 64'd0);  // wall went back
		send_item(CMD_READ, 32'hFFFF_FFFF, 1'b1, 64'd3000, 64'd0);
		send_item(CMD_READ, 32'd0, 1'b1, 64'd4000, 64'd0);     // wrap
		// period 0 puts the counter behind its baseline
		write_reg(REG_TICK_PERIOD, 64'd0);
		send_item(CMD_READ, 32'd5, 1'b1, 64'd5000, 64'd0);
		write_reg(REG_EVENT_FALLBACK, 64'd1);
		send_item(CMD_READ, 32'd0, 1'b1, 64'd0, 64'd0);
		send_item(CMD_NOTE, 32'd0, 1'b1, 64'd0, 64'h8000_0000_0000_0000);  // negative event
		send_item(CMD_READ, 32'd0, 1'b1, 64'd0, 64'd0);
		send_item(CMD_NOTE, 32'd0, 1'b0, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(CMD_READ, 32'hFFFF_FFFF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
		// largest period, alpha above 1000
		write_reg(REG_EVENT_FALLBACK, 64'd0);
		write_reg(REG_TICK_PERIOD, 64'hFFFF_FFFF_FFFF);
		write_reg(REG_ALPHA, 64'd1023);
		send_item(CMD_NOTE, 32'd0, 1'b1, 64'd0, 64'd77);
		send_item(CMD_READ, 32'h8000_0000, 1'b1, 64'd6000, 64'd0);
	endtask

	// counter and wall advance together with random skew; rate stays mostly unclamped
	task automatic test_tracked_rate(input int n_items);
		logic [63:0] trk_ticks;
		logic [63:0] trk_wall;
		longint      dt;
		longint      skew;
		longint      adv;
		int          pick;
		int          k;
		write_reg(REG_EVENT_FALLBACK, 64'd0);
		write_reg(REG_TICK_PERIOD, ONE_NS_TICK - 64'd524288 + $urandom_range(0, 1048576));
		write_reg(REG_UPDATE_INTERVAL, 64'($urandom_range(0, 200000)));
		write_reg(REG_MIN_WINDOW, 64'($urandom_range(0, 1 << 22)));
		write_reg(REG_ALPHA, 64'($urandom_range(0, 1023)));
		// restart the wall track so the total advance since baseline looks nominal
		trk_ticks = {wrap_count, last_low};
		trk_wall  = base_wall + (scale_ticks(trk_ticks) - base_cnt_ns);
		for (k = 0; k < n_items; k++) begin
			pick = $urandom_range(0, 99);
			if (k == n_items / 2 || pick < 2) begin
				// sender holds off until the block is empty
				wait_drained();
			end
			if (pick < 80) begin
				dt = longint'(($urandom_range(0, 7) == 0) ? $urandom_range(1 << 26, 1 << 29)
					: $urandom_range(1, 1 << 16));
				skew = longint'($urandom_range(0, 160)) - 80;
				adv  = dt + (dt * skew) / 1000;
				trk_ticks = trk_ticks + dt;
				trk_wall  = trk_wall + 64'(adv);
				send_item(CMD_READ, trk_ticks[31:0], 1'b1, trk_wall, {$urandom, $urandom});
			end else if (pick < 87) begin
				send_item(CMD_READ, $urandom, 1'b0, {$urandom, $urandom}, {$urandom, $urandom});
			end else if (pick < 93) begin
				send_item(CMD_NOTE, $urandom, 1'($urandom_range(0, 1)), {$urandom, $urandom},
					{$urandom, $urandom});
			end else begin
				// good read stamped before the wall time of the last tracked read
				trk_ticks = trk_ticks + $urandom_range(1, 1000);
				send_item(CMD_READ, trk_ticks[31:0], 1'b1, trk_wall - $urandom_range(1, 5000),
					64'd0);
			end
		end
	endtask

	// frame-event mode: notes store, reads replay; counter fields ignored
	task automatic test_fallback_events(input int n_items);
		logic [63:0] evt;
		int          k;
		write_reg(REG_ALPHA, 64'd0);
		write_reg(REG_EVENT_FALLBACK, 64'd1);
		for (k = 0; k < n_items; k++) begin
			evt = ($urandom_range(0, 3) == 0) ? {32'd0, $urandom} : {$urandom, $urandom};
			send_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
				{$urandom, $urandom}, evt);
		end
		write_reg(REG_EVENT_FALLBACK, 64'd0);
	endtask

	// wrap on every other read with the largest period until time saturates
	task automatic test_wrap_saturation(input int n_reads);
		logic [31:0] low;
		int          k;
		write_reg(REG_TICK_PERIOD, 64'hFFFF_FFFF_FFFF);
		write_reg(REG_UPDATE_INTERVAL, 64'hFFFF_FFFF);
		write_reg(REG_MIN_WINDOW, 64'hFFFF_FFFF);
		write_reg(REG_ALPHA, 64'($urandom_range(0, 1023)));
		for (k = 0; k < n_reads; k++) begin
			if ($urandom_range(0, 6) == 0)
				send_item(1'($urandom_range(0, 1)), $urandom, 1'b0, {$urandom, $urandom},
					{$urandom, $urandom});
			low     = $urandom;
			low[31] = k[0];  // low half then high half: one wrap per pair
			send_item(CMD_READ, low, 1'b1, {$urandom, $urandom}, {$urandom, $urandom});
		end
	endtask

	// ---------------------------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------------------------
	initial begin : run_tests
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_tracked_rate(170);
		test_tracked_rate(170);
		test_fallback_events(100);
		test_wrap_saturation(260);

		// all stimulus in; let the last results and any stray ones come out
		wait_drained();
		repeat (500) @(posedge clk);
		if (mismatch_count == 0 && clock_expect.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
